FILE: hw/rtl/msrs_pkg.sv
package msrs_pkg;

	localparam int          TABLE_LEN  = 8;
	localparam int          TIDX_W     = $clog2(TABLE_LEN);
	localparam logic [3:0]  NUM_STEPS  = 4'd8;
	localparam logic [3:0]  STEP_IDX_MAX = 4'd15;
	localparam logic [16:0] CENTRE_POS = 17'd32768;

	typedef enum logic [1:0] {
		REQ_UPDATE = 2'd0,
		REQ_START  = 2'd1,
		REQ_ABORT  = 2'd2
	} req_t;

	localparam logic [2:0] CFG_TICK_PERIOD   = 3'd0;
	localparam logic [2:0] CFG_SETTLE        = 3'd1;
	localparam logic [2:0] CFG_STEP          = 3'd2;
	localparam logic [2:0] CFG_CENTRE_FORCE  = 3'd3;
	localparam logic [2:0] CFG_CENTRE_TOL    = 3'd4;
	localparam logic [2:0] CFG_CENTRE_TMO    = 3'd5;

	typedef struct packed {
		logic [15:0] tick_period_ms;
		logic [15:0] settle_ms;
		logic [15:0] step_ms;
		logic [14:0] centre_force;
		logic [14:0] centre_tolerance;
		logic [15:0] centre_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic        centring;
		logic        stepping;
		logic [3:0]  step_index;
		logic        step_negative;
		logic [31:0] phase_start_ms;
		logic [31:0] last_tick_ms;
		logic [31:0] centre_start_ms;
	} seq_state_t;

	typedef struct packed {
		logic               owns_channel;
		logic               force_valid;
		logic signed [15:0] force_cmd;
		logic               log_valid;
		logic signed [15:0] log_force;
		logic [31:0]        log_elapsed_ms;
		logic [15:0]        log_steering;
		logic               log_end;
		logic               running;
	} result_t;

	function automatic logic [14:0] step_mag(input logic [3:0] idx);
		logic [TIDX_W-1:0] ti;
		logic [14:0]       mag;
		ti = (idx >= 4'(TABLE_LEN)) ? TIDX_W'(TABLE_LEN - 1) : idx[TIDX_W-1:0];
		unique case (ti)
			3'd0:    mag = 15'd3000;
			3'd1:    mag = 15'd5000;
			3'd2:    mag = 15'd7000;
			3'd3:    mag = 15'd10000;
			3'd4:    mag = 15'd14000;
			3'd5:    mag = 15'd19000;
			3'd6:    mag = 15'd25000;
			default: mag = 15'd32000;
		endcase
		return mag;
	endfunction

endpackage

FILE: hw/rtl/msrs_core.sv
module msrs_core import msrs_pkg::*; (
	input  cfg_t        cfg,
	input  seq_state_t  st,
	input  logic [1:0]  req_type,
	input  logic [31:0] now_ms,
	input  logic [15:0] steering,
	output seq_state_t  nxt,
	output result_t     res
);

	logic [31:0]        since_tick;
	logic [31:0]        since_phase;
	logic [31:0]        since_centre;
	logic signed [16:0] err;
	logic signed [16:0] tol;
	logic               off;
	logic               err_pos;
	logic signed [15:0] cforce;
	logic signed [15:0] sforce;
	logic [3:0]         idx_inc;

	assign since_tick   = now_ms - st.last_tick_ms;
	assign since_phase  = now_ms - st.phase_start_ms;
	assign since_centre = now_ms - st.centre_start_ms;
	assign err     = $signed({1'b0, steering}) - $signed(CENTRE_POS);
	assign tol     = $signed({2'b00, cfg.centre_tolerance});
	assign off     = (err > tol) || (err < -tol);
	assign err_pos = err > 17'sd0;
	assign cforce  = err_pos ? -$signed({1'b0, cfg.centre_force})
	                         : $signed({1'b0, cfg.centre_force});
	assign sforce  = st.step_negative ? -$signed({1'b0, step_mag(st.step_index)})
	                                  : $signed({1'b0, step_mag(st.step_index)});
	assign idx_inc = (st.step_index < STEP_IDX_MAX) ? st.step_index + 4'd1 : st.step_index;

	always_comb begin
		nxt = st;
		res = '0;
		unique case (req_type)
			REQ_START: nxt.active = 1'b1;
			REQ_ABORT: nxt.active = 1'b0;
			REQ_UPDATE: begin
				if (!st.active) begin
					nxt.step_index      = 4'd0;
					nxt.stepping        = 1'b0;
					nxt.centring        = 1'b1;
					nxt.phase_start_ms  = now_ms;
					nxt.centre_start_ms = now_ms;
				end else if (since_tick < {16'd0, cfg.tick_period_ms}) begin
					res.owns_channel = 1'b1;
				end else begin
					nxt.last_tick_ms = now_ms;
					res.owns_channel = 1'b1;
					res.force_valid  = 1'b1;
					if (st.centring) begin
						if (off && (since_centre < {16'd0, cfg.centre_timeout_ms})) begin
							res.force_cmd      = cforce;
							nxt.phase_start_ms = now_ms;
						end else if (since_phase >= {16'd0, cfg.settle_ms}) begin
							nxt.centring       = 1'b0;
							nxt.step_negative  = err_pos;
							nxt.phase_start_ms = now_ms;
							nxt.stepping       = 1'b1;
						end
					end else if (!st.stepping) begin
						if (since_phase >= {16'd0, cfg.settle_ms}) begin
							nxt.centring        = 1'b1;
							nxt.phase_start_ms  = now_ms;
							nxt.centre_start_ms = now_ms;
						end
					end else begin
						res.force_cmd      = sforce;
						res.log_valid      = 1'b1;
						res.log_force      = sforce;
						res.log_elapsed_ms = since_phase;
						res.log_steering   = steering;
						if (since_phase >= {16'd0, cfg.step_ms}) begin
							nxt.stepping       = 1'b0;
							nxt.centring       = 1'b1;
							nxt.phase_start_ms = now_ms;
							nxt.step_index     = idx_inc;
							if (idx_inc >= NUM_STEPS) begin
								nxt.active    = 1'b0;
								res.force_cmd = 16'sd0;
								res.log_end   = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		res.running = nxt.active;
	end

endmodule

FILE: hw/rtl/motor_step_response_sequencer_unit.sv
// Step-response test sequencer.
// A result is offered once its request has passed the input register and the result register.
// Throughput: one request per cycle while rsp_stall does not hold a pending result; the sequence
// state updates in the cycle the request leaves the input register.
// Reset (async, active low) clears the sequence state and loads register defaults.
module motor_step_response_sequencer_unit import msrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        steering,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic               owns_channel,
	output logic               force_valid,
	output logic signed [15:0] force_cmd,
	output logic               log_valid,
	output logic signed [15:0] log_force,
	output logic [31:0]        log_elapsed_ms,
	output logic [15:0]        log_steering,
	output logic               log_end,
	output logic               running
);

	cfg_t        cfg_q;
	seq_state_t  state_q;
	seq_state_t  state_nxt;
	result_t     res_nxt;
	result_t     res_q;
	logic        valid_s1;
	logic [1:0]  req_type_s1;
	logic [31:0] now_ms_s1;
	logic [15:0] steering_s1;
	logic        rsp_valid_q;
	logic        adv;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms    <= 16'd10;
			cfg_q.settle_ms         <= 16'd500;
			cfg_q.step_ms           <= 16'd250;
			cfg_q.centre_force      <= 15'd9000;
			cfg_q.centre_tolerance  <= 15'd7000;
			cfg_q.centre_timeout_ms <= 16'd2500;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TICK_PERIOD:  cfg_q.tick_period_ms    <= cfg_data;
				CFG_SETTLE:       cfg_q.settle_ms         <= cfg_data;
				CFG_STEP:         cfg_q.step_ms           <= cfg_data;
				CFG_CENTRE_FORCE: cfg_q.centre_force      <= cfg_data[14:0];
				CFG_CENTRE_TOL:   cfg_q.centre_tolerance  <= cfg_data[14:0];
				CFG_CENTRE_TMO:   cfg_q.centre_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_type_s1 <= req_type;
			now_ms_s1   <= now_ms;
			steering_s1 <= steering;
		end
	end

	msrs_core u_core (
		.cfg      (cfg_q),
		.st       (state_q),
		.req_type (req_type_s1),
		.now_ms   (now_ms_s1),
		.steering (steering_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign owns_channel   = res_q.owns_channel;
	assign force_valid    = res_q.force_valid;
	assign force_cmd      = res_q.force_cmd;
	assign log_valid      = res_q.log_valid;
	assign log_force      = res_q.log_force;
	assign log_elapsed_ms = res_q.log_elapsed_ms;
	assign log_steering   = res_q.log_steering;
	assign log_end        = res_q.log_end;
	assign running        = res_q.running;

endmodule

FILE: verif/tb_motor_step_response_sequencer_unit.sv
module tb_motor_step_response_sequencer_unit;
	import msrs_pkg::*;

	localparam logic [1:0] REQ_IGNORED  = 2'd3;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         PHASE_ITEMS  = 240;
	localparam int         NUM_PHASES   = 8;
	localparam int         DRAIN_CYCLES = 4;

	class step_seq_scoreboard;
		cfg_t       regs;
		seq_state_t st;
		result_t    awaited[$];
		int         fails;
		int         checked;
		int         finished;
		int         step_force [TABLE_LEN];

		function new();
			step_force = '{3000, 5000, 7000, 10000, 14000, 19000, 25000, 32000};
			regs.tick_period_ms    = 16'd10;
			regs.settle_ms         = 16'd500;
			regs.step_ms           = 16'd250;
			regs.centre_force      = 15'd9000;
			regs.centre_tolerance  = 15'd7000;
			regs.centre_timeout_ms = 16'd2500;
			st = '0;
		endfunction

		function void apply_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
			CFG_TICK_PERIOD:  regs.tick_period_ms = data;
			CFG_SETTLE:       regs.settle_ms = data;
			CFG_STEP:         regs.step_ms = data;
			CFG_CENTRE_FORCE: regs.centre_force = data[14:0];
			CFG_CENTRE_TOL:   regs.centre_tolerance = data[14:0];
			CFG_CENTRE_TMO:   regs.centre_timeout_ms = data;
			default: ;
			endcase
		endfunction

		// one transaction in, one predicted outcome queued
		function void note_request(logic [1:0] rq, logic [31:0] t, logic [15:0] s);
			result_t     r;
			int          err;
			int          tol;
			int          mag;
			int          ti;
			logic [31:0] el;
			r = '0;
			case (rq)
			REQ_START: st.active = 1'b1;
			REQ_ABORT: st.active = 1'b0;
			REQ_UPDATE: begin
				if (!st.active) begin
					st.step_index      = '0;
					st.stepping        = 1'b0;
					st.centring        = 1'b1;
					st.phase_start_ms  = t;
					st.centre_start_ms = t;
				end else if (32'(t - st.last_tick_ms) < regs.tick_period_ms) begin
					r.owns_channel = 1'b1;
				end else begin
					st.last_tick_ms = t;
					r.owns_channel  = 1'b1;
					r.force_valid   = 1'b1;
					if (st.centring) begin
						err = int'(s) - 32768;
						tol = int'(regs.centre_tolerance);
						if ((err > tol || err < -tol) &&
								32'(t - st.centre_start_ms) < regs.centre_timeout_ms) begin
							mag = int'(regs.centre_force);
							if (err > 0)
								mag = -mag;
							r.force_cmd = mag[15:0];
							st.phase_start_ms = t;
						end else if (32'(t - st.phase_start_ms) >= regs.settle_ms) begin
							st.centring       = 1'b0;
							st.step_negative  = (err > 0);
							st.phase_start_ms = t;
							st.stepping       = 1'b1;
						end
					end else if (!st.stepping) begin
						if (32'(t - st.phase_start_ms) >= regs.settle_ms) begin
							st.centring        = 1'b1;
							st.phase_start_ms  = t;
							st.centre_start_ms = t;
						end
					end else begin
						ti  = (st.step_index < TABLE_LEN) ? int'(st.step_index) : TABLE_LEN - 1;
						mag = st.step_negative ? -step_force[ti] : step_force[ti];
						el  = t - st.phase_start_ms;
						r.force_cmd      = mag[15:0];
						r.log_valid      = 1'b1;
						r.log_force      = mag[15:0];
						r.log_elapsed_ms = el;
						r.log_steering   = s;
						if (el >= regs.step_ms) begin
							st.stepping       = 1'b0;
							st.centring       = 1'b1;
							st.phase_start_ms = t;
							if (st.step_index < STEP_IDX_MAX)
								st.step_index++;
							if (st.step_index >= NUM_STEPS) begin
								st.active   = 1'b0;
								r.force_cmd = '0;
								r.log_end   = 1'b1;
								finished++;
							end
						end
					end
				end
			end
			default: ;
			endcase
			r.running = st.active;
			awaited.push_back(r);
		endfunction

		task report_mismatch(string msg);
			fails++;
			$display("MISMATCH at result %0d: %s", checked, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = awaited.pop_front();
			compare_field("owns_channel", 32'(got.owns_channel), 32'(want.owns_channel));
			compare_field("force_valid", 32'(got.force_valid), 32'(want.force_valid));
			compare_field("force_cmd", 32'(got.force_cmd), 32'(want.force_cmd));
			compare_field("log_valid", 32'(got.log_valid), 32'(want.log_valid));
			compare_field("log_force", 32'(got.log_force), 32'(want.log_force));
			compare_field("log_elapsed_ms", got.log_elapsed_ms, want.log_elapsed_ms);
			compare_field("log_steering", 32'(got.log_steering), 32'(want.log_steering));
			compare_field("log_end", 32'(got.log_end), 32'(want.log_end));
			compare_field("running", 32'(got.running), 32'(want.running));
			checked++;
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         req_type;
	logic [31:0]        now_ms;
	logic [15:0]        steering;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               rsp_valid;
	logic               rsp_stall;
	logic               owns_channel;
	logic               force_valid;
	logic signed [15:0] force_cmd;
	logic               log_valid;
	logic signed [15:0] log_force;
	logic [31:0]        log_elapsed_ms;
	logic [15:0]        log_steering;
	logic               log_end;
	logic               running;

	step_seq_scoreboard sb = new();
	result_t            seen;
	logic [31:0]        clock_ms;
	bit                 src_idle;
	bit                 sink_idle;
	int                 sink_hold;
	int                 cycles;
	int                 sent;
	int                 settings_loaded;
	int                 phase_end;
	int                 ph;
	int                 i;
	int unsigned        tp;

	motor_step_response_sequencer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_type       (req_type),
		.now_ms         (now_ms),
		.steering       (steering),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.owns_channel   (owns_channel),
		.force_valid    (force_valid),
		.force_cmd      (force_cmd),
		.log_valid      (log_valid),
		.log_force      (log_force),
		.log_elapsed_ms (log_elapsed_ms),
		.log_steering   (log_steering),
		.log_end        (log_end),
		.running        (running)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			seen = {owns_channel, force_valid, force_cmd, log_valid, log_force,
				log_elapsed_ms, log_steering, log_end, running};
			sb.check_result(seen);
			sink_hold = sink_idle ? $urandom_range(0, 7) : 0;
		end
	end

	always @(negedge clk) begin
		if (sink_hold > 0) begin
			rsp_stall <= 1'b1;
			sink_hold--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, sb.awaited.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_req(input logic [1:0] rq, input logic [31:0] t, input logic [15:0] s);
		int gap;
		gap = src_idle ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= rq;
		now_ms    <= t;
		steering  <= s;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(rq, t, s);
		sent++;
	endtask

	task automatic program_reg(input logic [2:0] idx, input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.apply_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] tick, input logic [15:0] settle,
			input logic [15:0] hold, input logic [14:0] force_mag,
			input logic [14:0] tol, input logic [15:0] tmo);
		wait_idle();
		program_reg(CFG_TICK_PERIOD, tick);
		program_reg(CFG_SETTLE, settle);
		program_reg(CFG_STEP, hold);
		program_reg(CFG_CENTRE_FORCE, {1'b0, force_mag});
		program_reg(CFG_CENTRE_TOL, {1'b0, tol});
		program_reg(CFG_CENTRE_TMO, tmo);
		settings_loaded++;
	endtask

	function automatic logic [31:0] next_gap_ms();
		int unsigned per;
		int          r;
		per = sb.regs.tick_period_ms;
		r = $urandom_range(0, 99);
		if (r < 15)
			return $urandom_range(0, per - 1);
		else if (r < 90)
			return per + $urandom_range(0, per);
		else if (r < 97)
			return $urandom_range(0, 200000);
		return $urandom;
	endfunction

	// mix of in-band, band-edge, end-stop and arbitrary positions
	function automatic logic [15:0] pick_steering();
		int tol;
		int r;
		int v;
		tol = sb.regs.centre_tolerance;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = 32768 - tol + int'($urandom_range(0, 2 * tol));
		else if (r < 55)
			v = $urandom_range(0, 1) ? 32768 + tol + 1 : 32768 - tol - 1;
		else if (r < 62)
			v = $urandom_range(0, 1) ? 65535 : 0;
		else
			v = $urandom_range(0, 65535);
		if (v > 65535)
			v = 65535;
		if (v < 0)
			v = 0;
		return v[15:0];
	endfunction

	task automatic run_sequence(input int stop_at);
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		else if (r < 5)
			clock_ms = $urandom;
		// mostly a clean arm; occasionally restart on stale state
		if ($urandom_range(0, 9) != 0) begin
			if (sb.st.active)
				send_req(REQ_ABORT, clock_ms, pick_steering());
			send_req(REQ_UPDATE, clock_ms, pick_steering());
		end
		send_req(REQ_START, clock_ms, pick_steering());
		while (sb.st.active && sent < stop_at) begin
			r = $urandom_range(0, 199);
			if (r == 0) begin
				send_req(REQ_ABORT, clock_ms, pick_steering());
			end else if (r == 1) begin
				send_req(REQ_START, clock_ms, pick_steering());
			end else if (r == 2) begin
				send_req(REQ_IGNORED, $urandom, 16'($urandom_range(0, 65535)));
			end else if (r == 3) begin
				wait_idle();
			end else begin
				clock_ms += next_gap_ms();
				send_req(REQ_UPDATE, clock_ms, pick_steering());
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_type  = REQ_UPDATE;
		now_ms    = '0;
		steering  = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TICK_PERIOD;
		cfg_data  = '0;
		rsp_stall = 1'b0;
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		sink_hold = 0;
		cycles    = 0;
		sent      = 0;
		clock_ms  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fresh from reset: start before any update lands in the zero-force settle branch
		send_req(REQ_IGNORED, 32'hFFFF_FFFF, 16'hFFFF);
		send_req(REQ_START, 32'd0, 16'd32768);
		send_req(REQ_START, 32'd1, 16'd32768);
		send_req(REQ_UPDATE, 32'd3, 16'd0);
		send_req(REQ_UPDATE, 32'd10, 16'd0);
		send_req(REQ_UPDATE, 32'd510, 16'd0);
		send_req(REQ_UPDATE, 32'd520, 16'd0);
		send_req(REQ_ABORT, 32'd530, 16'd0);

		// fastest timing, widest band, no centring drive: full run of steps to the end
		load_settings(16'd1, 16'd0, 16'd1, 15'h7FFF, 15'h7FFF, 16'd0);
		send_req(REQ_UPDATE, 32'd1000, 16'd0);
		send_req(REQ_START, 32'd1000, 16'd0);
		for (i = 0; i < 16; i++)
			send_req(REQ_UPDATE, 32'd1001 + i, (i % 4 == 0) ? 16'd0 :
				(i[1] ? 16'hFFFF : 16'd1));
		// restart without re-arming: index already past the table
		send_req(REQ_START, 32'd1020, 16'd0);
		send_req(REQ_UPDATE, 32'd1021, 16'hFFFF);
		send_req(REQ_UPDATE, 32'd1022, 16'd1);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
			0: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0, 15'd0, 16'hFFFF);
			1: load_settings(16'd10, 16'd500, 16'd250, 15'd9000, 15'd7000, 16'd2500);
			default: begin
				tp = $urandom_range(1, 40);
				load_settings(16'(tp), 16'(tp * $urandom_range(0, 4)),
					16'(tp * $urandom_range(1, 4)),
					15'($urandom_range(0, 32767)), 15'($urandom_range(0, 12000)),
					16'(tp * $urandom_range(0, 8)));
			end
			endcase
			src_idle  = (ph % 4 != 1) && ($urandom_range(0, 3) != 0);
			sink_idle = (ph % 4 != 1) && ($urandom_range(0, 3) != 0);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end) begin
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 5))
						send_req(2'($urandom_range(0, 3)), $urandom,
							16'($urandom_range(0, 65535)));
				end else begin
					run_sequence(phase_end);
				end
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests under %0d register settings, checked %0d results.",
			sent, settings_loaded, sb.checked);
		$display("Step sequences run to completion: %0d, mismatches: %0d.",
			sb.finished, sb.fails);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
